>>> src/tdc_frame_decoder_assert.svh
// Assertion macros shared by the frame decoder checks.
`ifndef TDC_FRAME_DECODER_ASSERT_SVH
`define TDC_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tdc_fd_pkg.sv
// Shared types, codes and helper functions for the TDC frame decoder.
package tdc_fd_pkg;

  // Result kind codes
  localparam logic [1:0] KindEvent = 2'd0;
  localparam logic [1:0] KindNormal = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;
  localparam logic [1:0] KindOverCount = 2'd3;

  // Sync word bounds: "HDR0" .. "HDR5"
  localparam logic [31:0] SyncLow = 32'h4844_5230;
  localparam logic [31:0] SyncHigh = 32'h4844_5235;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInitReset = 16'h0F4A;

  // Configuration register addresses (word index)
  localparam logic RegCrcEnable = 1'b0;
  localparam logic RegCrcInit = 1'b1;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        crc_status;
    logic [2:0]  chip_number;
    logic [31:0] frame_number;
    logic [9:0]  lead_coarse_time;
    logic [9:0]  lead_start_conv;
    logic [9:0]  lead_end_conv;
    logic [7:0]  lead_channel_tac;
    logic [9:0]  trail_coarse_time;
    logic [9:0]  trail_start_conv;
    logic [9:0]  trail_end_conv;
    logic [7:0]  trail_channel_tac;
  } result_t;

  // CRC-16 over one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Gray to binary: each bit is the parity of itself and all bits above
  function automatic logic [9:0] gray10_decode(input logic [9:0] g);
    logic [9:0] p;
    for (int i = 0; i < 10; i++) begin
      p[i] = ^(g >> i);
    end
    return p;
  endfunction

endpackage

>>> src/tdc_frame_decoder.sv
// Byte-serial TDC frame decoder: sync hunt, frame parse, event unpack and CRC check.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   input    | in        | in_valid_i / in_stall_o   | data_byte_i
//   output   | out       | out_valid_o / out_stall_i | result_kind_o .. trail_channel_tac_o
//   config   | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One byte is taken per cycle while in_stall_o is low; its result, if any, lands in the
// output register at the same edge and is shown from the next cycle, or in the skid
// register behind it while a result waits there; the skid register keeps bytes flowing,
// and in_stall_o rises only when both hold a result.
// Reset clears the parse state, the output valids and the CRC register to 0x0F4A;
// no clearing pass is needed.
module tdc_frame_decoder #(
  parameter int MaxEvents = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic        crc_status_o,
  output logic [2:0]  chip_number_o,
  output logic [31:0] frame_number_o,
  output logic [9:0]  lead_coarse_time_o,
  output logic [9:0]  lead_start_conv_o,
  output logic [9:0]  lead_end_conv_o,
  output logic [7:0]  lead_channel_tac_o,
  output logic [9:0]  trail_coarse_time_o,
  output logic [9:0]  trail_start_conv_o,
  output logic [9:0]  trail_end_conv_o,
  output logic [7:0]  trail_channel_tac_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tdc_fd_pkg::*;

  localparam int EvtW = $clog2(MaxEvents + 1);

  // Parse phase codes
  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhCount = 3'd1;
  localparam logic [2:0] PhFrameId = 3'd2;
  localparam logic [2:0] PhEvent = 3'd3;
  localparam logic [2:0] PhPad = 3'd4;
  localparam logic [2:0] PhCrcHi = 3'd5;
  localparam logic [2:0] PhCrcLo = 3'd6;

  localparam logic [3:0] LastEventByte = 4'd9;
  localparam logic [3:0] LastIdByte = 4'd3;

  // Configuration registers
  logic        crc_en_q;
  logic [15:0] crc_init_q;

  // Parse state
  logic [31:0]     sync_q, sync_d;
  logic [2:0]      phase_q, phase_d;
  logic [3:0]      byte_idx_q, byte_idx_d;
  logic [EvtW-1:0] events_left_q, events_left_d;
  logic [31:0]     frame_num_q, frame_num_d;
  logic [2:0]      chip_q, chip_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_hi_q, crc_hi_d;
  logic [1:0]      frame_kind_q, frame_kind_d;
  logic [7:0]      event_bytes [9];

  // Output and skid registers
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    res_valid, in_acc, out_take, new_res, eb_wr;

  logic [6:0]  half_count;
  logic [15:0] crc_rx;
  logic [15:0] crc_next;

  assign in_acc = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;
  assign new_res = in_acc && res_valid;
  assign half_count = data_byte_i[7:1];
  assign crc_rx = {crc_hi_q, data_byte_i};
  assign crc_next = crc16_byte(crc_q, data_byte_i);

  // Configuration write and read-back
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q <= 1'b0;
      crc_init_q <= CrcInitReset;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegCrcEnable) begin
        crc_en_q <= pwdata[0];
      end else begin
        crc_init_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegCrcInit) begin
      prdata = {16'd0, crc_init_q};
    end else begin
      prdata = {31'd0, crc_en_q};
    end
  end

  // Next parse state and result for the byte on the input
  always_comb begin
    sync_d = sync_q;
    phase_d = phase_q;
    byte_idx_d = byte_idx_q;
    events_left_d = events_left_q;
    frame_num_d = frame_num_q;
    chip_d = chip_q;
    crc_d = crc_q;
    crc_hi_d = crc_hi_q;
    frame_kind_d = frame_kind_q;
    eb_wr = 1'b0;
    res_valid = 1'b0;
    res = '0;
    res.chip_number = chip_q;
    res.frame_number = frame_num_q;

    unique case (phase_q)
      PhCount: begin
        crc_d = crc16_byte(crc_init_q, data_byte_i);
        if (half_count == 7'd0 || half_count > 7'(MaxEvents)) begin
          // empty or over-count frame body ends at the count byte (CRC bytes follow if enabled)
          frame_kind_d = (half_count == 7'd0) ? KindEmpty : KindOverCount;
          if (crc_en_q) begin
            phase_d = PhCrcHi;
          end else begin
            res_valid = 1'b1;
            res.result_kind = frame_kind_d;
            sync_d = '0;
            phase_d = PhHunt;
            byte_idx_d = '0;
          end
        end else begin
          events_left_d = half_count[EvtW-1:0];
          byte_idx_d = '0;
          phase_d = PhFrameId;
        end
      end
      PhFrameId: begin
        crc_d = crc_next;
        frame_num_d = {frame_num_q[23:0], data_byte_i};
        if (byte_idx_q == LastIdByte) begin
          byte_idx_d = '0;
          phase_d = PhEvent;
        end else begin
          byte_idx_d = byte_idx_q + 4'd1;
        end
      end
      PhEvent: begin
        crc_d = crc_next;
        if (byte_idx_q < LastEventByte) begin
          eb_wr = 1'b1;
          byte_idx_d = byte_idx_q + 4'd1;
        end else begin
          // tenth byte completes the event: unpack and emit
          res_valid = 1'b1;
          res.result_kind = KindEvent;
          res.lead_coarse_time = gray10_decode({event_bytes[0], event_bytes[1][7:6]});
          res.lead_start_conv = gray10_decode({event_bytes[1][5:0], event_bytes[2][7:4]});
          res.lead_end_conv = gray10_decode({event_bytes[2][3:0], event_bytes[3][7:2]});
          res.lead_channel_tac = event_bytes[4];
          res.trail_coarse_time = gray10_decode({event_bytes[5], event_bytes[6][7:6]});
          res.trail_start_conv = gray10_decode({event_bytes[6][5:0], event_bytes[7][7:4]});
          res.trail_end_conv = gray10_decode({event_bytes[7][3:0], event_bytes[8][7:2]});
          res.trail_channel_tac = data_byte_i;
          byte_idx_d = '0;
          events_left_d = events_left_q - EvtW'(1);
          if (events_left_q == EvtW'(1)) begin
            phase_d = PhPad;
          end
        end
      end
      PhPad: begin
        // padding byte enters the CRC as zero
        crc_d = crc16_byte(crc_q, 8'd0);
        frame_kind_d = KindNormal;
        if (crc_en_q) begin
          phase_d = PhCrcHi;
        end else begin
          res_valid = 1'b1;
          res.result_kind = KindNormal;
          sync_d = '0;
          phase_d = PhHunt;
          byte_idx_d = '0;
        end
      end
      PhCrcHi: begin
        crc_hi_d = data_byte_i;
        phase_d = PhCrcLo;
      end
      PhCrcLo: begin
        res_valid = 1'b1;
        res.result_kind = frame_kind_q;
        res.crc_status = (crc_rx != crc_q);
        sync_d = '0;
        phase_d = PhHunt;
        byte_idx_d = '0;
      end
      default: begin
        // hunt: shift the byte in and look for the sync word
        sync_d = {sync_q[23:0], data_byte_i};
        if (sync_d >= SyncLow && sync_d <= SyncHigh) begin
          chip_d = sync_d[2:0];
          phase_d = PhCount;
          byte_idx_d = '0;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  // Advance parse state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= '0;
      phase_q <= PhHunt;
      byte_idx_q <= '0;
      events_left_q <= '0;
      frame_num_q <= '0;
      chip_q <= '0;
      crc_q <= CrcInitReset;
      crc_hi_q <= '0;
      frame_kind_q <= '0;
    end else if (in_acc) begin
      sync_q <= sync_d;
      phase_q <= phase_d;
      byte_idx_q <= byte_idx_d;
      events_left_q <= events_left_d;
      frame_num_q <= frame_num_d;
      chip_q <= chip_d;
      crc_q <= crc_d;
      crc_hi_q <= crc_hi_d;
      frame_kind_q <= frame_kind_d;
    end
  end

  // Hold the first nine bytes of the event
  always_ff @(posedge clk_i) begin
    if (in_acc && eb_wr) begin
      event_bytes[byte_idx_q] <= data_byte_i;
    end
  end

  // Output register with skid stage: valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= new_res;
      end
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register with skid stage: payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (new_res) begin
        out_q <= res;
      end
    end else if (new_res) begin
      skid_q <= res;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_kind_o = out_q.result_kind;
  assign crc_status_o = out_q.crc_status;
  assign chip_number_o = out_q.chip_number;
  assign frame_number_o = out_q.frame_number;
  assign lead_coarse_time_o = out_q.lead_coarse_time;
  assign lead_start_conv_o = out_q.lead_start_conv;
  assign lead_end_conv_o = out_q.lead_end_conv;
  assign lead_channel_tac_o = out_q.lead_channel_tac;
  assign trail_coarse_time_o = out_q.trail_coarse_time;
  assign trail_start_conv_o = out_q.trail_start_conv;
  assign trail_end_conv_o = out_q.trail_end_conv;
  assign trail_channel_tac_o = out_q.trail_channel_tac;

endmodule

>>> src/tdc_fd_checker.sv
// Port-level checks for the TDC frame decoder, bound to the top level.
`include "tdc_frame_decoder_assert.svh"

module tdc_fd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic        crc_status_o,
  input logic [2:0]  chip_number_o,
  input logic [31:0] frame_number_o,
  input logic [9:0]  lead_coarse_time_o,
  input logic [9:0]  lead_end_conv_o,
  input logic [7:0]  lead_channel_tac_o,
  input logic [9:0]  trail_coarse_time_o,
  input logic [7:0]  trail_channel_tac_o
);
  import tdc_fd_pkg::*;

  // Stalled result holds its payload
  `TFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(result_kind_o) && $stable(frame_number_o) && $stable(lead_coarse_time_o), "stalled result changed")

  // Input stalls only while a result is waiting
  `TFD_ASSERT_NOW(a_stall_needs_out, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with empty output")

  // An event item never flags a CRC mismatch
  `TFD_ASSERT_NOW(a_event_crc, clk_i, rst_ni, out_valid_o && result_kind_o == KindEvent, !crc_status_o, "event item carries CRC status")

  // Frame end items carry no event contents
  `TFD_ASSERT_NOW(a_status_zero, clk_i, rst_ni, out_valid_o && result_kind_o != KindEvent, lead_coarse_time_o == 10'd0 && lead_end_conv_o == 10'd0 && lead_channel_tac_o == 8'd0 && trail_coarse_time_o == 10'd0 && trail_channel_tac_o == 8'd0, "status item has event data")

  // Chip id comes from a sync digit 0 to 5
  `TFD_ASSERT_NOW(a_chip_range, clk_i, rst_ni, out_valid_o, chip_number_o <= 3'd5, "chip id out of range")

endmodule

bind tdc_frame_decoder tdc_fd_checker u_tdc_fd_checker (.*);

>>> verif/tdc_frame_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the TDC frame decoder: framed byte streams against a predictor.
module tdc_frame_decoder_tb;
  import tdc_fd_pkg::*;

  localparam int MaxEvents = 64;
  localparam int LimitCycles = 500000;
  localparam int SettleCycles = 8;
  localparam int PhaseBytes = 250;
  localparam int ReportLimit = 10;

  // Predicts decoded results from accepted bytes and checks the block against them
  class decoded_result_board;
    typedef enum logic [2:0] {
      PhHunt, PhCount, PhFrameId, PhEvent, PhPad, PhCrcHi, PhCrcLo
    } parse_phase_e;

    bit           crc_en;
    logic [15:0]  crc_seed;
    parse_phase_e phase;
    logic [31:0]  sync_window;
    int           byte_idx;
    int           events_left;
    logic [7:0]   ev_bytes [9];
    logic [31:0]  frame_no;
    logic [2:0]   chip;
    logic [15:0]  crc;
    logic [7:0]   crc_hi;
    logic [1:0]   frame_kind;
    result_t      expected_results[$];
    int unsigned  failures;

    function void clear();
      crc_en = 1'b0;
      crc_seed = CrcInitReset;
      phase = PhHunt;
      sync_window = '0;
      byte_idx = 0;
      events_left = 0;
      frame_no = '0;
      chip = '0;
      crc = CrcInitReset;
      crc_hi = '0;
      frame_kind = '0;
      expected_results.delete();
      failures = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == RegCrcEnable) begin
        crc_en = value[0];
      end else begin
        crc_seed = value[15:0];
      end
    endfunction

    // CRC-16/0x1021, MSB first: fold the byte into the top and shift eight times
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      repeat (8) begin
        r = r[15] ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
      end
      return r;
    endfunction

    static function logic [9:0] gray_to_bin(logic [9:0] g);
      logic [9:0] v;
      v[9] = g[9];
      for (int i = 8; i >= 0; i--) begin
        v[i] = v[i + 1] ^ g[i];
      end
      return v;
    endfunction

    // Close the frame with a status item and restart the hunt from an empty window
    function void push_status(logic [1:0] kind, bit bad);
      result_t r;
      r = '0;
      r.result_kind = kind;
      r.crc_status = bad;
      r.chip_number = chip;
      r.frame_number = frame_no;
      expected_results.push_back(r);
      sync_window = '0;
      phase = PhHunt;
      byte_idx = 0;
    endfunction

    function void end_body(logic [1:0] kind);
      frame_kind = kind;
      if (crc_en) begin
        phase = PhCrcHi;
      end else begin
        push_status(kind, 1'b0);
      end
    endfunction

    function void decode_byte(logic [7:0] b);
      logic [79:0] ev;
      logic [6:0]  n;
      result_t     r;
      case (phase)
        PhCount: begin
          crc = crc_next(crc_seed, b);
          n = b[7:1];
          if (n == 0) begin
            end_body(KindEmpty);
          end else if (n > MaxEvents) begin
            end_body(KindOverCount);
          end else begin
            events_left = n;
            byte_idx = 0;
            phase = PhFrameId;
          end
        end
        PhFrameId: begin
          crc = crc_next(crc, b);
          frame_no = {frame_no[23:0], b};
          byte_idx++;
          if (byte_idx >= 4) begin
            byte_idx = 0;
            phase = PhEvent;
          end
        end
        PhEvent: begin
          crc = crc_next(crc, b);
          if (byte_idx < 9) begin
            ev_bytes[byte_idx] = b;
            byte_idx++;
          end else begin
            // Unpack the ten event bytes; two low bits of bytes 3 and 8 are unused
            ev = {ev_bytes[0], ev_bytes[1], ev_bytes[2], ev_bytes[3], ev_bytes[4],
                  ev_bytes[5], ev_bytes[6], ev_bytes[7], ev_bytes[8], b};
            r = '0;
            r.result_kind = KindEvent;
            r.chip_number = chip;
            r.frame_number = frame_no;
            r.lead_coarse_time = gray_to_bin(ev[79:70]);
            r.lead_start_conv = gray_to_bin(ev[69:60]);
            r.lead_end_conv = gray_to_bin(ev[59:50]);
            r.lead_channel_tac = ev[47:40];
            r.trail_coarse_time = gray_to_bin(ev[39:30]);
            r.trail_start_conv = gray_to_bin(ev[29:20]);
            r.trail_end_conv = gray_to_bin(ev[19:10]);
            r.trail_channel_tac = ev[7:0];
            expected_results.push_back(r);
            byte_idx = 0;
            events_left--;
            if (events_left == 0) begin
              phase = PhPad;
            end
          end
        end
        PhPad: begin
          // Padding counts as a zero byte in the checksum
          crc = crc_next(crc, 8'h00);
          end_body(KindNormal);
        end
        PhCrcHi: begin
          crc_hi = b;
          phase = PhCrcLo;
        end
        PhCrcLo: begin
          push_status(frame_kind, {crc_hi, b} != crc);
        end
        default: begin
          sync_window = {sync_window[23:0], b};
          if (sync_window >= SyncLow && sync_window <= SyncHigh) begin
            chip = 3'(sync_window - SyncLow);
            phase = PhCount;
            byte_idx = 0;
          end else begin
            phase = PhHunt;
          end
        end
      endcase
    endfunction

    function bit at_hunt();
      return phase == PhHunt;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("%0t: result with none expected, kind %0d, frame %0h",
                   $time, got.result_kind, got.frame_number);
        end
        return;
      end
      want = expected_results.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("crc_status", want.crc_status, got.crc_status);
      compare_field("chip_number", want.chip_number, got.chip_number);
      compare_field("frame_number", want.frame_number, got.frame_number);
      compare_field("lead_coarse_time", want.lead_coarse_time, got.lead_coarse_time);
      compare_field("lead_start_conv", want.lead_start_conv, got.lead_start_conv);
      compare_field("lead_end_conv", want.lead_end_conv, got.lead_end_conv);
      compare_field("lead_channel_tac", want.lead_channel_tac, got.lead_channel_tac);
      compare_field("trail_coarse_time", want.trail_coarse_time, got.trail_coarse_time);
      compare_field("trail_start_conv", want.trail_start_conv, got.trail_start_conv);
      compare_field("trail_end_conv", want.trail_end_conv, got.trail_end_conv);
      compare_field("trail_channel_tac", want.trail_channel_tac, got.trail_channel_tac);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic        crc_status_o;
  logic [2:0]  chip_number_o;
  logic [31:0] frame_number_o;
  logic [9:0]  lead_coarse_time_o;
  logic [9:0]  lead_start_conv_o;
  logic [9:0]  lead_end_conv_o;
  logic [7:0]  lead_channel_tac_o;
  logic [9:0]  trail_coarse_time_o;
  logic [9:0]  trail_start_conv_o;
  logic [9:0]  trail_end_conv_o;
  logic [7:0]  trail_channel_tac_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  decoded_result_board results;
  logic [7:0]  stream_q[$];
  bit          cur_crc_en;
  logic [15:0] cur_crc_seed;
  int          items_sent;
  int          burst_left;
  int          cycle_count;
  int          rx_cycle;
  int          rx_mode;

  tdc_frame_decoder #(
    .MaxEvents(MaxEvents)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .crc_status_o       (crc_status_o),
    .chip_number_o      (chip_number_o),
    .frame_number_o     (frame_number_o),
    .lead_coarse_time_o (lead_coarse_time_o),
    .lead_start_conv_o  (lead_start_conv_o),
    .lead_end_conv_o    (lead_end_conv_o),
    .lead_channel_tac_o (lead_channel_tac_o),
    .trail_coarse_time_o(trail_coarse_time_o),
    .trail_start_conv_o (trail_start_conv_o),
    .trail_end_conv_o   (trail_end_conv_o),
    .trail_channel_tac_o(trail_channel_tac_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #1 clk_i = ~clk_i;

  // Take results and stall on a pattern picked at random from five modes
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results.check_result({result_kind_o, crc_status_o, chip_number_o, frame_number_o,
                            lead_coarse_time_o, lead_start_conv_o, lead_end_conv_o,
                            lead_channel_tac_o, trail_coarse_time_o, trail_start_conv_o,
                            trail_end_conv_o, trail_channel_tac_o});
    end
    rx_cycle++;
    if (rx_cycle % 128 == 0) begin
      rx_mode = $urandom_range(0, 4);
    end
    case (rx_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      3: out_stall_i <= ((rx_cycle % 8) < 3);
      default: out_stall_i <= ((rx_cycle % 40) < 20);
    endcase
  end

  // Abort a run that hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL tdc_frame_decoder");
    $finish;
  end

  // Offer one item, hold it until taken, then maybe open a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    results.decode_byte(b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // Hold the sender until every expected result is in, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    results.write_reg(idx, value);
    if (idx == RegCrcEnable) begin
      cur_crc_en = value[0];
    end else begin
      cur_crc_seed = value[15:0];
    end
  endtask

  task automatic set_config(input bit en, input logic [15:0] seed);
    write_reg(RegCrcEnable, {31'd0, en});
    write_reg(RegCrcInit, {16'd0, seed});
  endtask

  function automatic void push_sync(logic [2:0] chip);
    stream_q.push_back(SyncLow[31:24]);
    stream_q.push_back(SyncLow[23:16]);
    stream_q.push_back(SyncLow[15:8]);
    stream_q.push_back(SyncLow[7:0] + 8'(chip));
  endfunction

  function automatic logic [7:0] pick_byte(int mode);
    if (mode == 0) return 8'h00;
    if (mode == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Queue a whole frame under the current settings, with a bad checksum on request
  function automatic void add_frame(logic [2:0] chip, logic [7:0] count_b, bit corrupt);
    logic [15:0] crc;
    logic [7:0]  b;
    int          n;
    int          mode;
    push_sync(chip);
    stream_q.push_back(count_b);
    crc = decoded_result_board::crc_next(cur_crc_seed, count_b);
    n = count_b[7:1];
    if (n >= 1 && n <= MaxEvents) begin
      mode = $urandom_range(0, 7);
      repeat (4) begin
        b = pick_byte(mode);
        stream_q.push_back(b);
        crc = decoded_result_board::crc_next(crc, b);
      end
      repeat (n) begin
        mode = $urandom_range(0, 9);
        repeat (10) begin
          b = pick_byte(mode);
          stream_q.push_back(b);
          crc = decoded_result_board::crc_next(crc, b);
        end
      end
      stream_q.push_back(8'($urandom));
      crc = decoded_result_board::crc_next(crc, 8'h00);
    end
    if (cur_crc_en) begin
      if (corrupt) crc = crc ^ (16'd1 << $urandom_range(0, 15));
      stream_q.push_back(crc[15:8]);
      stream_q.push_back(crc[7:0]);
    end
  endfunction

  // Mostly small frames, with empty and over-count frames mixed in
  function automatic logic [7:0] pick_count();
    int         p;
    logic [6:0] n;
    p = $urandom_range(0, 99);
    if (p < 8) begin
      n = 7'd0;
    end else if (p < 16) begin
      return 8'($urandom_range(130, 255));
    end else if (p < 22) begin
      n = 7'($urandom_range(5, 16));
    end else begin
      n = 7'($urandom_range(1, 4));
    end
    return {n, 1'($urandom)};
  endfunction

  // Noise leans on sync letters and digits around the valid range
  function automatic void add_noise(int len);
    repeat (len) begin
      if ($urandom_range(0, 1) == 0) begin
        stream_q.push_back(8'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: stream_q.push_back(SyncLow[31:24]);
          1: stream_q.push_back(SyncLow[23:16]);
          2: stream_q.push_back(SyncLow[15:8]);
          default: stream_q.push_back(SyncLow[7:0] - 8'd1 + 8'($urandom_range(0, 8)));
        endcase
      end
    end
  endfunction

  task automatic run_directed();
    // Over-count frame on chip 0
    add_frame(3'd0, 8'hFF, 1'b0);
    // One all-ones event on chip 5; padding 'H' must not seed the next hunt
    push_sync(3'd5);
    stream_q.push_back(8'h03);
    repeat (14) stream_q.push_back(8'hFF);
    stream_q.push_back(SyncLow[31:24]);
    stream_q.push_back(SyncLow[23:16]);
    stream_q.push_back(SyncLow[15:8]);
    stream_q.push_back(SyncLow[7:0] + 8'd6);
    // Empty frame with the odd count bit set
    add_frame(3'd3, 8'h01, 1'b0);
    send_stream();
  endtask

  task automatic run_phase(input int budget, input bit with_big);
    int first;
    int r;
    int cut;
    first = items_sent;
    if (with_big) begin
      add_frame(3'($urandom_range(0, 5)), {7'd64, 1'($urandom)}, 1'b0);
      send_stream();
    end
    while (items_sent - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_noise($urandom_range(1, 12));
      end else begin
        add_frame(3'($urandom_range(0, 5)), pick_count(), $urandom_range(0, 3) == 0);
        // Break some frames off early
        if (r < 18) begin
          cut = $urandom_range(1, stream_q.size() - 1);
          repeat (cut) void'(stream_q.pop_back());
        end
      end
      send_stream();
      if ($urandom_range(0, 99) < 3) drain_results();
    end
    // Flush a frame left open so the next settings start from the hunt
    while (!results.at_hunt()) send_byte(8'h00);
    drain_results();
  endtask

  initial begin
    results = new;
    results.clear();
    cur_crc_en = 1'b0;
    cur_crc_seed = CrcInitReset;
    items_sent = 0;
    burst_left = 0;
    rx_cycle = 0;
    rx_mode = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    data_byte_i <= '0;
    out_stall_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain_results();

    run_phase(PhaseBytes, 1'b0);
    set_config(1'b1, 16'h0000);
    run_phase(PhaseBytes, 1'b1);
    set_config(1'b1, 16'hFFFF);
    run_phase(PhaseBytes, 1'b0);
    set_config(1'b0, 16'($urandom));
    run_phase(PhaseBytes, 1'b0);
    set_config(1'b1, 16'($urandom));
    run_phase(PhaseBytes, 1'b0);

    drain_results();
    if (results.failures == 0 && results.pending() == 0) begin
      $display("PASS tdc_frame_decoder");
    end else begin
      $display("FAIL tdc_frame_decoder");
    end
    $finish;
  end

endmodule
